### rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants for the frame rotate / flip / crop unit.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int CFG_W          = 9;      // width of geometry registers
    localparam int IDX_W          = 2 * CFG_W;
    localparam int PIX_W          = 32;     // packed r,g,b,a beat payload
    localparam int DEF_MAX_DIM    = 256;
    localparam int DEF_PIXEL_BITS = 32;

    localparam logic [2:0]       RST_MODE   = 3'd0;
    localparam logic [CFG_W-1:0] RST_WIDTH  = 9'd256;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 9'd256;
    localparam logic [CFG_W-1:0] RST_XA     = 9'd0;
    localparam logic [CFG_W-1:0] RST_YA     = 9'd0;
    localparam logic [CFG_W-1:0] RST_XB     = 9'd256;
    localparam logic [CFG_W-1:0] RST_YB     = 9'd256;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_WIDTH  = 3'd1,
        CFG_HEIGHT = 3'd2,
        CFG_XA     = 3'd3,
        CFG_YA     = 3'd4,
        CFG_XB     = 3'd5,
        CFG_YB     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_CROP    = 3'd0,
        MODE_ROT_CCW = 3'd1,
        MODE_ROT_CW  = 3'd2,
        MODE_FLIP_TB = 3'd3,
        MODE_FLIP_LR = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_pixel;
        logic             error;
    } t_out_item;

    typedef struct packed {
        logic [2:0]       mode;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] xa;
        logic [CFG_W-1:0] ya;
        logic [CFG_W-1:0] xb;
        logic [CFG_W-1:0] yb;
    } t_cfg;

    // Geometry decision for the current fetch position.
    typedef struct packed {
        logic [CFG_W-1:0] sr;       // source row
        logic [CFG_W-1:0] sc;       // source column
        logic             err;
        logic             last;
        logic [CFG_W-1:0] nxt_row;
        logic [CFG_W-1:0] nxt_col;
        logic             room;     // frame store still takes loads
    } t_geom;

endpackage

### rtl/frame_rotate_flip_crop_unit.sv
// ----------------------------------------------------------------------------
// frame_rotate_flip_crop_unit
// Loads a frame of packed pixels into a frame store, then returns it one
// pixel per fetch beat, cropped, rotated or flipped per the mode register.
// ----------------------------------------------------------------------------
// Load beat: written at the accepting edge; busy stays low, one load per cycle while not busy.
// Fetch beat: strobed after the address cycle (address multiply into the store
//   read port, then registered read data); busy is high for the address cycle
//   only, so a new fetch is taken in the result beat. Results cannot be stalled.
// Reset (sync, active low) clears counters, position, FSM and config registers;
//   the frame store has no reset and no clearing pass.
// ----------------------------------------------------------------------------
module frame_rotate_flip_crop_unit import frc_pkg::*; #(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    // result channel
    output logic             o_strobe,
    output t_out_item        o_result,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW     = $clog2(MAX_DIM * MAX_DIM);       // store address
    localparam int LCW    = $clog2(MAX_DIM * MAX_DIM + 1);   // load counter
    localparam int DATA_W = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

    t_state           r_state, n_state;
    t_cfg             r_cfg;
    logic [LCW-1:0]   r_load_count;
    logic [CFG_W-1:0] r_row, r_col;

    // fetch in flight: source position and flags held to the result beat
    logic [CFG_W-1:0] r_sr, r_sc;
    logic             r_err, r_last;

    t_geom            geom;
    logic [CFG_W-1:0] width;
    logic             accept, fetch_acc, load_acc;
    logic             st_we, st_re;
    logic [IDX_W-1:0] rd_idx;
    logic [DATA_W-1:0] rd_data;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= RST_MODE;
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.xa     <= RST_XA;
            r_cfg.ya     <= RST_YA;
            r_cfg.xb     <= RST_XB;
            r_cfg.yb     <= RST_YB;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[2:0];
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                CFG_XA:     r_cfg.xa     <= i_cfg_data;
                CFG_YA:     r_cfg.ya     <= i_cfg_data;
                CFG_XB:     r_cfg.xb     <= i_cfg_data;
                CFG_YB:     r_cfg.yb     <= i_cfg_data;
                default: ;  // unused index: dropped
            endcase
        end
    end

    // -------------------------------------------------------------- geometry
    frc_geom #(
        .MAX_DIM (MAX_DIM),
        .LCW     (LCW)
    ) u_geom (
        .i_cfg        (r_cfg),
        .i_load_count (r_load_count),
        .i_row        (r_row),
        .i_col        (r_col),
        .o_width      (width),
        .o_geom       (geom)
    );

    // ------------------------------------------------------------- handshake
    // Items are taken while idle and during the result beat.
    assign accept    = start && !busy;
    assign fetch_acc = accept && i_item.kind;
    assign load_acc  = accept && !i_item.kind;

    // ------------------------------------------------------ frame store port
    // Loads write at the accepting edge; the read is issued in the address
    // cycle, so both never hit the port in the same cycle.
    assign st_we  = load_acc && geom.room;
    assign st_re  = (r_state == ST_ADDR);
    assign rd_idx = IDX_W'(r_sr) * IDX_W'(width) + IDX_W'(r_sc);

    frc_store #(
        .ADDR_W (AW),
        .DATA_W (DATA_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (AW'(r_load_count)),
        .i_wdata (i_item.pixel_in[DATA_W-1:0]),
        .i_re    (st_re),
        .i_raddr (AW'(rd_idx)),
        .o_rdata (rd_data)
    );

    // -------------------------------------------------- counters and position
    // Position and load count move at the fetch accept, so a beat taken right
    // after the last pixel already sees the rearmed frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_row        <= '0;
            r_col        <= '0;
        end else if (st_we) begin
            r_load_count <= r_load_count + LCW'(1);
        end else if (fetch_acc && !geom.err) begin
            r_row <= geom.nxt_row;
            r_col <= geom.nxt_col;
            if (geom.last) begin
                r_load_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch_acc) begin
            r_sr   <= geom.sr;
            r_sc   <= geom.sc;
            r_err  <= geom.err;
            r_last <= geom.last;
        end
    end

    // ------------------------------------------------------------------- FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (fetch_acc) n_state = ST_ADDR;
            ST_ADDR: n_state = ST_OUT;
            ST_OUT:  n_state = fetch_acc ? ST_ADDR : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy                = (r_state == ST_ADDR);
        o_strobe            = (r_state == ST_OUT);
        o_result.pixel_out  = r_err ? '0 : PIX_W'(rd_data);
        o_result.last_pixel = r_last && !r_err;
        o_result.error      = r_err;
    end

endmodule

### rtl/frc_store.sv
// ----------------------------------------------------------------------------
// frc_store
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frc_store #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/frc_geom.sv
// ----------------------------------------------------------------------------
// frc_geom
// Output geometry: saturates frame size, orders and clamps the crop window,
// maps the output position to a source position and steps the raster.
// ----------------------------------------------------------------------------
module frc_geom import frc_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int LCW     = 17
) (
    input  t_cfg             i_cfg,
    input  logic [LCW-1:0]   i_load_count,
    input  logic [CFG_W-1:0] i_row,
    input  logic [CFG_W-1:0] i_col,
    output logic [CFG_W-1:0] o_width,
    output t_geom            o_geom
);

    logic [CFG_W-1:0] w, h;
    logic [IDX_W-1:0] total;
    logic             loaded;
    logic [CFG_W-1:0] xa, xb, ya, yb, xlo, xhi, ylo, yhi;
    logic [CFG_W-1:0] ow, oh, sr, sc;
    logic             mode_ok;
    logic             err;

    // frame size saturated into 1..MAX_DIM
    always_comb begin
        w = i_cfg.width;
        if (i_cfg.width == '0) begin
            w = CFG_W'(1);
        end else if (32'(i_cfg.width) > MAX_DIM) begin
            w = CFG_W'(MAX_DIM);
        end
        h = i_cfg.height;
        if (i_cfg.height == '0) begin
            h = CFG_W'(1);
        end else if (32'(i_cfg.height) > MAX_DIM) begin
            h = CFG_W'(MAX_DIM);
        end
    end

    assign total  = IDX_W'(w) * IDX_W'(h);
    assign loaded = 32'(i_load_count) >= 32'(total);

    always_comb begin
        xa  = (i_cfg.xa > w) ? w : i_cfg.xa;
        xb  = (i_cfg.xb > w) ? w : i_cfg.xb;
        ya  = (i_cfg.ya > h) ? h : i_cfg.ya;
        yb  = (i_cfg.yb > h) ? h : i_cfg.yb;
        xlo = (xa < xb) ? xa : xb;
        xhi = (xa < xb) ? xb : xa;
        ylo = (ya < yb) ? ya : yb;
        yhi = (ya < yb) ? yb : ya;
    end

    always_comb begin
        mode_ok = 1'b1;
        ow      = w;
        oh      = h;
        sr      = i_row;
        sc      = i_col;
        case (i_cfg.mode)
            MODE_CROP: begin
                ow = xhi - xlo;
                oh = yhi - ylo;
                sr = ylo + i_row;
                sc = xlo + i_col;
            end
            MODE_ROT_CCW: begin
                ow = h;
                oh = w;
                sr = i_col;
                sc = w - CFG_W'(1) - i_row;
            end
            MODE_ROT_CW: begin
                ow = h;
                oh = w;
                sr = h - CFG_W'(1) - i_col;
                sc = i_row;
            end
            MODE_FLIP_TB: begin
                sr = h - CFG_W'(1) - i_row;
            end
            MODE_FLIP_LR: begin
                sc = w - CFG_W'(1) - i_col;
            end
            default: begin
                mode_ok = 1'b0;
            end
        endcase
    end

    assign err = !loaded || !mode_ok || (ow == '0) || (oh == '0)
               || (i_row >= oh) || (i_col >= ow);

    // raster step
    always_comb begin
        o_geom.sr      = sr;
        o_geom.sc      = sc;
        o_geom.err     = err;
        o_geom.room    = !loaded;
        o_geom.last    = 1'b0;
        o_geom.nxt_row = i_row;
        o_geom.nxt_col = i_col;
        if ({1'b0, i_col} + 10'd1 < {1'b0, ow}) begin
            o_geom.nxt_col = i_col + CFG_W'(1);
        end else if ({1'b0, i_row} + 10'd1 < {1'b0, oh}) begin
            o_geom.nxt_col = '0;
            o_geom.nxt_row = i_row + CFG_W'(1);
        end else begin
            o_geom.nxt_col = '0;
            o_geom.nxt_row = '0;
            o_geom.last    = !err;
        end
    end

    assign o_width = w;

endmodule

### rtl/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks of the frame rotate / flip / crop unit.
// ----------------------------------------------------------------------------
module frc_checker import frc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_strobe,
    input t_out_item o_result
);

    // every fetch beat gets its result after the address cycle
    a_fetch_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.kind) |-> ##2 o_strobe)
        else $error("fetch beat without result");

    // a load beat never holds the unit busy
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_item.kind) |=> !busy)
        else $error("load beat stalled the unit");

    // results only follow the address cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without a fetch in flight");

    // an error result carries no pixel and no end-of-frame mark
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.error) |-> (o_result.pixel_out == '0 && !o_result.last_pixel))
        else $error("error result carries data");

endmodule

bind frame_rotate_flip_crop_unit frc_checker u_frc_checker (.*);
